@@ rtl/fpba_pkg.sv @@
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared types and constants for the fit policy block allocator: channel
// payloads, the scan token that walks the cell row, fit codes and states.
// ----------------------------------------------------------------------------
package fpba_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_BLOCKS_DEF = 16;
   localparam int SIZE_BITS_DEF  = 16;

   // Fixed field widths of the channels and registers
   localparam int FIELD_SIZE_W  = 16;
   localparam int FIELD_INDEX_W = 4;
   localparam int FIELD_NUM_W   = 4;
   localparam int MODE_W        = 2;
   localparam int COUNT_W       = 5;

   // Fit policy codes (any other code acts as first fit)
   localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
   localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
   localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

   // Item function codes
   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_ALLOC = 1'b1;

   typedef struct packed {
      logic                     func;
      logic [FIELD_INDEX_W-1:0] block_index;
      logic [FIELD_SIZE_W-1:0]  block_size;
      logic [FIELD_SIZE_W-1:0]  request_size;
      logic                     new_run;
   } req_type;

   typedef struct packed {
      logic                   granted;
      logic [FIELD_NUM_W-1:0] block_number;
   } rsp_type;

   // Scan token handed from cell to cell
   typedef struct packed {
      logic                    valid;
      logic                    new_run;
      logic [MODE_W-1:0]       fit_mode;
      logic [COUNT_W-1:0]      block_count;
      logic [FIELD_SIZE_W-1:0] request_size;
      logic                    found;
   } scan_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

endpackage

@@ rtl/fpba_cell.sv @@
// ----------------------------------------------------------------------------
// fpba_cell
// One table entry: holds a block size and its used mark, checks the passing
// scan token against the entry and hands the updated token to the next cell.
// ----------------------------------------------------------------------------
module fpba_cell
   import fpba_pkg::*;
#(
   parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
   parameter int SIZE_BITS  = SIZE_BITS_DEF,
   parameter int CELL_INDEX = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   // token from the previous cell
   input  scan_ctl_type                  ctl_i,
   input  logic [$clog2(MAX_BLOCKS)-1:0] pick_i,
   input  logic [SIZE_BITS-1:0]          pick_size_i,
   // token to the next cell
   output scan_ctl_type                  ctl_o,
   output logic [$clog2(MAX_BLOCKS)-1:0] pick_o,
   output logic [SIZE_BITS-1:0]          pick_size_o,
   // load write
   input  logic                          wr_en,
   input  logic [FIELD_INDEX_W-1:0]      wr_index,
   input  logic [SIZE_BITS-1:0]          wr_size,
   // mark the granted block
   input  logic                          set_en,
   input  logic [$clog2(MAX_BLOCKS)-1:0] set_index
);

   localparam int IDX_W = $clog2(MAX_BLOCKS);
   localparam int CW    = (IDX_W + 1 > COUNT_W) ? IDX_W + 1 : COUNT_W;
   localparam int WW    = (IDX_W > FIELD_INDEX_W) ? IDX_W : FIELD_INDEX_W;
   localparam int SW    = (SIZE_BITS > FIELD_SIZE_W) ? SIZE_BITS : FIELD_SIZE_W;

   logic [SIZE_BITS-1:0] size_ff;
   logic [SIZE_BITS-1:0] size_in;
   logic                 used_ff;
   logic                 used_in;
   scan_ctl_type         ctl_ff;
   scan_ctl_type         ctl_in;
   logic [IDX_W-1:0]     pick_ff;
   logic [IDX_W-1:0]     pick_in;
   logic [SIZE_BITS-1:0] pick_size_ff;
   logic [SIZE_BITS-1:0] pick_size_in;

   logic in_range;
   logic free_now;
   logic fits;
   logic candidate;
   logic take;
   logic wr_hit;
   logic set_hit;

   // Evaluate this entry against the token
   always_comb begin
      in_range  = CW'(ctl_i.block_count) > CW'(CELL_INDEX);
      free_now  = !used_ff || ctl_i.new_run;
      fits      = SW'(size_ff) >= SW'(ctl_i.request_size);
      candidate = ctl_i.valid && in_range && free_now && fits;
      take      = candidate && (!ctl_i.found ||
                  (ctl_i.fit_mode == FIT_BEST  && size_ff < pick_size_i) ||
                  (ctl_i.fit_mode == FIT_WORST && size_ff > pick_size_i));
      wr_hit    = wr_en && (WW'(wr_index) == WW'(CELL_INDEX));
      set_hit   = set_en && (set_index == IDX_W'(CELL_INDEX));
   end

   // Next token and entry state
   always_comb begin
      ctl_in       = ctl_i;
      ctl_in.found = ctl_i.found || candidate;
      pick_in      = take ? IDX_W'(CELL_INDEX) : pick_i;
      pick_size_in = take ? size_ff : pick_size_i;
      size_in      = wr_hit ? wr_size : size_ff;
      if (wr_hit) begin
         used_in = 1'b0;
      end else if (set_hit) begin
         used_in = 1'b1;
      end else if (ctl_i.valid && ctl_i.new_run) begin
         used_in = 1'b0;
      end else begin
         used_in = used_ff;
      end
   end

   // Hold the entry and advance the token
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
         ctl_ff  <= '0;
      end else begin
         used_ff <= used_in;
         ctl_ff  <= ctl_in;
      end
      size_ff      <= size_in;
      pick_ff      <= pick_in;
      pick_size_ff <= pick_size_in;
   end

   assign ctl_o       = ctl_ff;
   assign pick_o      = pick_ff;
   assign pick_size_o = pick_size_ff;

endmodule

@@ rtl/fit_policy_block_allocator.sv @@
// ----------------------------------------------------------------------------
// fit_policy_block_allocator
// Fixed-block allocator with first, best and worst fit over a row of cells.
// ----------------------------------------------------------------------------
// A load beat writes one block size and frees that block; its result beat
// (granted 0) is ready in the cycle after the load is taken. An allocation
// beat launches a scan token into a row of MAX_BLOCKS cells, one cell per
// table entry; the token moves one cell per cycle and carries the best pick
// so far, and the commit state then marks the chosen block used once the
// result register is free. The next beat is taken no sooner than the edge
// at which the pending result beat is taken, so a stalled result stalls
// the input. Only one item is in work at a time. Registers: fit_mode at
// byte address 0, block_count at byte address 4.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator
   import fpba_pkg::*;
#(
   parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
   parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int IDX_W = $clog2(MAX_BLOCKS);

   localparam logic CSR_FIT_MODE    = 1'b0;
   localparam logic CSR_BLOCK_COUNT = 1'b1;

   // Register file
   logic [MODE_W-1:0]  fit_mode_ff;
   logic [MODE_W-1:0]  fit_mode_in;
   logic [COUNT_W-1:0] block_count_ff;
   logic [COUNT_W-1:0] block_count_in;
   logic               csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      fit_mode_in    = fit_mode_ff;
      block_count_in = block_count_ff;
      if (csr_write) begin
         case (paddr[2])
            CSR_FIT_MODE:    fit_mode_in    = pwdata[MODE_W-1:0];
            CSR_BLOCK_COUNT: block_count_in = pwdata[COUNT_W-1:0];
            default:         fit_mode_in    = fit_mode_ff;
         endcase
      end
      case (paddr[2])
         CSR_FIT_MODE:    prdata = 32'(fit_mode_ff);
         CSR_BLOCK_COUNT: prdata = 32'(block_count_ff);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff    <= FIT_FIRST;
         block_count_ff <= COUNT_W'(16);
      end else begin
         fit_mode_ff    <= fit_mode_in;
         block_count_ff <= block_count_in;
      end
   end

   // Cell row
   scan_ctl_type         ctl_w       [MAX_BLOCKS+1];
   logic [IDX_W-1:0]     pick_w      [MAX_BLOCKS+1];
   logic [SIZE_BITS-1:0] pick_size_w [MAX_BLOCKS+1];
   logic [MAX_BLOCKS:0]  token_at;

   logic                 req_fire;
   logic                 wr_en;
   logic                 set_en;

   assign req_fire = req_valid && req_ready;
   assign wr_en    = req_fire && (req_data.func == FUNC_LOAD);

   // Launch the token at the head of the row
   always_comb begin
      ctl_w[0].valid        = req_fire && (req_data.func == FUNC_ALLOC);
      ctl_w[0].new_run      = req_data.new_run;
      ctl_w[0].fit_mode     = fit_mode_ff;
      ctl_w[0].block_count  = block_count_ff;
      ctl_w[0].request_size = req_data.request_size;
      ctl_w[0].found        = 1'b0;
      pick_w[0]             = '0;
      pick_size_w[0]        = '0;
   end

   logic [IDX_W-1:0] pick_ff;
   logic [IDX_W-1:0] pick_in;
   logic             found_ff;
   logic             found_in;

   genvar g;
   generate
      for (g = 0; g < MAX_BLOCKS; g++) begin : g_cell
         fpba_cell #(
            .MAX_BLOCKS (MAX_BLOCKS),
            .SIZE_BITS  (SIZE_BITS),
            .CELL_INDEX (g)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctl_i       (ctl_w[g]),
            .pick_i      (pick_w[g]),
            .pick_size_i (pick_size_w[g]),
            .ctl_o       (ctl_w[g+1]),
            .pick_o      (pick_w[g+1]),
            .pick_size_o (pick_size_w[g+1]),
            .wr_en       (wr_en),
            .wr_index    (req_data.block_index),
            .wr_size     (SIZE_BITS'(req_data.block_size)),
            .set_en      (set_en),
            .set_index   (pick_ff)
         );
      end
      for (g = 0; g <= MAX_BLOCKS; g++) begin : g_tok
         assign token_at[g] = ctl_w[g].valid;
      end
   endgenerate

   // Sequencer and response register
   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   rsp_type   rsp_data_ff;
   rsp_type   rsp_data_in;
   logic      out_free;
   logic      rsp_load;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      set_en      = 1'b0;
      rsp_load    = 1'b0;
      rsp_data_in = rsp_data_ff;
      found_in    = found_ff;
      pick_in     = pick_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = out_free;
            if (req_fire) begin
               if (req_data.func == FUNC_LOAD) begin
                  rsp_load    = 1'b1;
                  rsp_data_in = '0;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // capture the pick as the token leaves the last cell
            if (ctl_w[MAX_BLOCKS].valid) begin
               found_in = ctl_w[MAX_BLOCKS].found;
               pick_in  = pick_w[MAX_BLOCKS];
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (out_free) begin
               set_en                   = found_ff;
               rsp_load                 = 1'b1;
               rsp_data_in.granted      = found_ff;
               rsp_data_in.block_number = found_ff ? FIELD_NUM_W'(pick_ff) : '0;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      found_ff    <= found_in;
      pick_ff     <= pick_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   a_one_token : assert property (@(posedge clock) disable iff (reset)
      $onehot0(token_at))
      else $error("more than one scan token in the cell row");

   a_tail_in_scan : assert property (@(posedge clock) disable iff (reset)
      ctl_w[MAX_BLOCKS].valid |-> state_ff == ST_SCAN)
      else $error("scan token left the row outside the scan state");

   a_no_launch_busy : assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !ctl_w[0].valid && !wr_en)
      else $error("item taken while an allocation is in work");

   a_commit_to_rsp : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT && out_free) |=> rsp_valid_ff
         && rsp_data_ff.granted == $past(found_ff))
      else $error("commit did not produce its response");

   a_nogrant_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.granted) |-> rsp_data_ff.block_number == '0)
      else $error("block number set on a response without grant");

endmodule

@@ bench/fit_policy_block_allocator_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_tb
// Self-checking bench for the first, best and worst fit block allocator.
// A short table of directed beats loads the size table and hits the edge
// cases. Phases of random loads and allocations follow, run under every fit
// code and a spread of block counts. Each response beat is checked against
// the expected result of its directed row or an in-bench allocation predictor.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_tb
   import fpba_pkg::*;
;

   localparam int NB             = MAX_BLOCKS_DEF;
   localparam int SW             = SIZE_BITS_DEF;
   localparam int PHASES         = 10;
   localparam int PHASE_BEATS    = 75;
   localparam int HOLDOFF_AT     = 400;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int PAUSE_AT       = 220;

   localparam logic [2:0]        ADDR_FIT_MODE    = 3'd0;
   localparam logic [2:0]        ADDR_BLOCK_COUNT = 3'd4;
   localparam logic [MODE_W-1:0] FIT_UNDEF        = 2'd3;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   // Predictor copy of the block's table and registers
   logic [SW-1:0]      table_size [NB];
   logic               table_used [NB];
   logic [MODE_W-1:0]  cur_mode;
   logic [COUNT_W-1:0] cur_count;

   rsp_type expected_grants [$];

   int error_count;
   int beats_in;
   int n_loads;
   int n_allocs;
   int n_grants;
   int n_settings;
   bit holdoff_done;

   typedef struct {
      logic [MODE_W-1:0]  mode;
      logic [COUNT_W-1:0] count;
      req_type            item;
      bit                 typed;
      rsp_type            want;
   } dir_row_type;

   dir_row_type dir_rows [$];

   fit_policy_block_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Timeout: allocator stopped making progress");
      $display("*** FAILED ***");
      $finish;
   end

   // Apply one beat to the predictor and return the response it implies
   task automatic predict_alloc(input req_type d, output rsp_type r);
      int  lim;
      int  pick;
      bit  found;
      bit  stop;
      r = '0;
      if (d.func == FUNC_LOAD) begin
         table_size[d.block_index] = d.block_size;
         table_used[d.block_index] = 1'b0;
      end else begin
         if (d.new_run) begin
            for (int j = 0; j < NB; j++) table_used[j] = 1'b0;
         end
         lim   = (int'(cur_count) > NB) ? NB : int'(cur_count);
         found = 1'b0;
         stop  = 1'b0;
         pick  = 0;
         for (int j = 0; j < lim; j++) begin
            if (!stop && !table_used[j] && table_size[j] >= d.request_size) begin
               if (!found) begin
                  found = 1'b1;
                  pick  = j;
                  stop  = (cur_mode != FIT_BEST && cur_mode != FIT_WORST);
               end else if (cur_mode == FIT_BEST && table_size[j] < table_size[pick]) begin
                  pick = j;
               end else if (cur_mode == FIT_WORST && table_size[j] > table_size[pick]) begin
                  pick = j;
               end
            end
         end
         if (found) begin
            table_used[pick] = 1'b1;
            r.granted        = 1'b1;
            r.block_number   = FIELD_NUM_W'(pick);
         end
      end
   endtask

   // Offer one beat, hold it until taken, then queue its expected response
   task automatic send_beat(input req_type d, input bit typed, input rsp_type want);
      rsp_type guess;
      req_valid <= 1'b1;
      req_data  <= d;
      do @(posedge clock); while (!req_ready);
      predict_alloc(d, guess);
      if (typed) guess = want;
      expected_grants.push_back(guess);
      beats_in++;
      if (d.func == FUNC_LOAD) n_loads++;
      else n_allocs++;
      if (guess.granted) n_grants++;
   endtask

   // Drop valid for an idle gap of length n, if n is positive
   task automatic idle_gap(input int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Drop valid and hold until every queued response has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_grants.size() != 0);
   endtask

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Write one register, read it back and compare
   task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
      logic [31:0] rd;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == ADDR_FIT_MODE) cur_mode = value[MODE_W-1:0];
      else cur_count = value[COUNT_W-1:0];
      // back-to-back read of the same register
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rd = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      if (rd !== value) begin
         $error("prdata mismatch at 0x%0h: expected 0x%0h, actual 0x%0h", addr, value, rd);
         error_count++;
      end
   endtask

   // Change settings only once the block has gone idle
   task automatic apply_config(input logic [MODE_W-1:0] mode, input logic [COUNT_W-1:0] count);
      wait_drained();
      if (mode != cur_mode) write_reg(ADDR_FIT_MODE, 32'(mode));
      if (count != cur_count) write_reg(ADDR_BLOCK_COUNT, 32'(count));
      n_settings++;
   endtask

   task automatic add_row(input logic [MODE_W-1:0] mode, input int count, input logic func,
                          input int idx, input int bsize, input int rsize, input logic nrun,
                          input bit typed, input logic g, input int num);
      dir_row_type row;
      row.mode               = mode;
      row.count              = COUNT_W'(count);
      row.item.func          = func;
      row.item.block_index   = FIELD_INDEX_W'(idx);
      row.item.block_size    = FIELD_SIZE_W'(bsize);
      row.item.request_size  = FIELD_SIZE_W'(rsize);
      row.item.new_run       = nrun;
      row.typed              = typed;
      row.want.granted       = g;
      row.want.block_number  = FIELD_NUM_W'(num);
      dir_rows.push_back(row);
   endtask

   // Random beat: mostly allocations, half of them aimed at sizes held in the table
   function automatic req_type rand_beat();
      req_type d;
      int      r;
      int      base;
      int      delta;
      d.func         = FUNC_ALLOC;
      d.block_index  = FIELD_INDEX_W'($urandom_range(0, NB - 1));
      d.block_size   = FIELD_SIZE_W'($urandom_range(0, 65535));
      d.request_size = FIELD_SIZE_W'($urandom_range(0, 65535));
      d.new_run      = 1'($urandom_range(0, 1));
      r = $urandom_range(0, 99);
      if (r < 25) begin
         d.func = FUNC_LOAD;
         r = $urandom_range(0, 99);
         if (r < 15) d.block_size = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
         else if (r < 60) d.block_size = FIELD_SIZE_W'($urandom_range(0, 15) * 256);
      end else begin
         d.new_run = ($urandom_range(0, 99) < 15);
         r = $urandom_range(0, 99);
         if (r < 50) begin
            base  = int'(table_size[$urandom_range(0, NB - 1)]);
            delta = $urandom_range(0, 3);
            d.request_size = FIELD_SIZE_W'((base >= delta) ? base - delta : 0);
         end else if (r < 75) begin
            d.request_size = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
         end else if (r < 90) begin
            d.request_size = FIELD_SIZE_W'($urandom_range(0, 4095));
         end
      end
      return d;
   endfunction

   // Response side: random stalls, one long hold-off while the sender keeps going
   initial begin : rsp_side
      int stall_pct;
      int span;
      span      = 0;
      stall_pct = 0;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!holdoff_done && beats_in >= HOLDOFF_AT) begin
            holdoff_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
         end else begin
            if (span == 0) begin
               span = $urandom_range(16, 96);
               case ($urandom_range(0, 3))
                  0: stall_pct = 0;
                  1: stall_pct = 10;
                  2: stall_pct = 40;
                  default: stall_pct = 70;
               endcase
            end
            span--;
            if ($urandom_range(0, 199) == 0) begin
               rsp_ready <= 1'b0;
               repeat ($urandom_range(10, 40)) @(posedge clock);
            end else begin
               rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
               @(posedge clock);
            end
         end
      end
   end

   // Check each response beat against the oldest expectation
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_grants.size() == 0) begin
            $error("response beat with nothing expected: granted %0d, block_number %0d",
                   rsp_data.granted, rsp_data.block_number);
            error_count++;
         end else begin
            want = expected_grants.pop_front();
            if (rsp_data.granted !== want.granted) begin
               $error("granted mismatch: expected %0d, actual %0d",
                      want.granted, rsp_data.granted);
               error_count++;
            end
            if (rsp_data.block_number !== want.block_number) begin
               $error("block_number mismatch: expected %0d, actual %0d",
                      want.block_number, rsp_data.block_number);
               error_count++;
            end
         end
      end
   end

   initial begin : stimulus
      logic [SW-1:0] fill [11];
      int            count_plan [PHASES];
      bit            quiet;
      dir_row_type   row;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      psel      <= 1'b0;
      penable   <= 1'b0;
      pwrite    <= 1'b0;
      paddr     <= '0;
      pwdata    <= '0;
      for (int j = 0; j < NB; j++) begin
         table_size[j] = '0;
         table_used[j] = 1'b0;
      end
      cur_mode     = FIT_FIRST;
      cur_count    = COUNT_W'(NB);
      error_count  = 0;
      beats_in     = 0;
      n_loads      = 0;
      n_allocs     = 0;
      n_grants     = 0;
      n_settings   = 0;
      holdoff_done = 1'b0;

      fill = '{16'd4096, 16'd8, 16'd65534, 16'd60, 16'd60, 16'd1, 16'd32768,
               16'd255, 16'd256, 16'd61, 16'd2};

      // Directed table: load four entries and the top index, then edge cases
      add_row(FIT_FIRST, 4, FUNC_LOAD, 0, 0, 0, 1'b0, 1'b1, 1'b0, 0);
      add_row(FIT_FIRST, 4, FUNC_LOAD, 1, 65535, 65535, 1'b1, 1'b1, 1'b0, 0);
      add_row(FIT_FIRST, 4, FUNC_LOAD, 2, 100, 0, 1'b0, 1'b1, 1'b0, 0);
      add_row(FIT_FIRST, 4, FUNC_LOAD, 3, 100, 0, 1'b0, 1'b1, 1'b0, 0);
      add_row(FIT_FIRST, 4, FUNC_LOAD, 15, 5, 0, 1'b0, 1'b1, 1'b0, 0);
      // zero request takes the zero-size entry, largest request the largest entry
      add_row(FIT_FIRST, 4, FUNC_ALLOC, 15, 65535, 0, 1'b1, 1'b1, 1'b1, 0);
      add_row(FIT_FIRST, 4, FUNC_ALLOC, 0, 0, 65535, 1'b0, 1'b1, 1'b1, 1);
      // no fit left
      add_row(FIT_FIRST, 4, FUNC_ALLOC, 0, 0, 65535, 1'b0, 1'b1, 1'b0, 0);
      // best fit tie, worst fit after a new run, undefined code as first fit
      add_row(FIT_BEST, 4, FUNC_ALLOC, 0, 0, 50, 1'b0, 1'b0, 1'b0, 0);
      add_row(FIT_WORST, 4, FUNC_ALLOC, 0, 0, 1, 1'b1, 1'b0, 1'b0, 0);
      add_row(FIT_UNDEF, 4, FUNC_ALLOC, 0, 0, 100, 1'b1, 1'b0, 1'b0, 0);
      // empty scan range never grants, then a one-entry range
      add_row(FIT_FIRST, 0, FUNC_ALLOC, 0, 0, 0, 1'b1, 1'b1, 1'b0, 0);
      add_row(FIT_FIRST, 1, FUNC_ALLOC, 0, 0, 0, 1'b1, 1'b0, 1'b0, 0);
      for (int j = 0; j < 11; j++) begin
         add_row(FIT_FIRST, 1, FUNC_LOAD, j + 4, int'(fill[j]), 0, 1'b0, 1'b1, 1'b0, 0);
      end
      // count above the table size saturates
      add_row(FIT_BEST, 31, FUNC_ALLOC, 0, 0, 60, 1'b1, 1'b0, 1'b0, 0);
      add_row(FIT_WORST, 16, FUNC_ALLOC, 0, 0, 65535, 1'b0, 1'b0, 1'b0, 0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table
      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         if (row.mode != cur_mode || row.count != cur_count) apply_config(row.mode, row.count);
         send_beat(row.item, row.typed, row.want);
         idle_gap(gap_len());
      end

      // Random phases across all fit codes and a spread of block counts
      count_plan    = '{16, 1, 31, 0, 17, 8, 16, 5, 12, 16};
      count_plan[7] = $urandom_range(2, 15);
      count_plan[8] = $urandom_range(0, 31);
      for (int ph = 0; ph < PHASES; ph++) begin
         apply_config(MODE_W'(ph % 4), COUNT_W'(count_plan[ph]));
         quiet = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < PHASE_BEATS; k++) begin
            // one full pause until the block has answered everything
            if (beats_in == PAUSE_AT) wait_drained();
            send_beat(rand_beat(), 1'b0, '0);
            if (!quiet) idle_gap(gap_len());
         end
      end

      wait_drained();
      repeat (NB + 4) @(posedge clock);
      if (expected_grants.size() != 0) begin
         $error("%0d expected response beats never arrived", expected_grants.size());
         error_count++;
      end

      $display("Sent %0d beats: %0d loads and %0d allocations, %0d of them granted.",
               beats_in, n_loads, n_allocs, n_grants);
      $display("Ran %0d register settings over all fit codes, block counts 0 to 31.",
               n_settings);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
